// ===== design/ddo_pkg.sv =====
// ---------------------------------------------------------------------------
// ddo_pkg - differential drive odometry shared definitions
// Fixed-point constants, register indexes and the CORDIC angle table.
// ---------------------------------------------------------------------------
`default_nettype none
package ddo_pkg;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 28;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LEFT_MM_PER_TICK  = 3'd0,
      REG_RIGHT_MM_PER_TICK = 3'd1,
      REG_SPEED_LIMIT       = 3'd2,
      REG_FILTER_GAIN       = 3'd3,
      REG_WHEEL_BASE        = 3'd4
   } csr_index_type;

   localparam logic signed [63:0] PI_Q29      = 64'sd1686629713;
   localparam logic signed [63:0] HALF_PI_Q29 = 64'sd843314856;
   localparam logic signed [63:0] CORDIC_K_Q30 = 64'sd652032874;

   function automatic logic signed [63:0] atan_q29(input logic [4:0] k);
      logic signed [63:0] v;
      unique case (k)
         5'd0:  v = 64'sd421657428;
         5'd1:  v = 64'sd248918914;
         5'd2:  v = 64'sd131521918;
         5'd3:  v = 64'sd66762579;
         5'd4:  v = 64'sd33510843;
         5'd5:  v = 64'sd16771757;
         5'd6:  v = 64'sd8387925;
         5'd7:  v = 64'sd4194218;
         5'd8:  v = 64'sd2097141;
         5'd9:  v = 64'sd1048574;
         5'd10: v = 64'sd524287;
         5'd11: v = 64'sd262143;
         5'd12: v = 64'sd131071;
         5'd13: v = 64'sd65535;
         5'd14: v = 64'sd32767;
         5'd15: v = 64'sd16383;
         5'd16: v = 64'sd8191;
         5'd17: v = 64'sd4095;
         5'd18: v = 64'sd2047;
         5'd19: v = 64'sd1023;
         5'd20: v = 64'sd511;
         5'd21: v = 64'sd255;
         5'd22: v = 64'sd127;
         5'd23: v = 64'sd63;
         5'd24: v = 64'sd31;
         5'd25: v = 64'sd15;
         5'd26: v = 64'sd7;
         5'd27: v = 64'sd3;
         5'd28: v = 64'sd1;
         default: v = 64'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== design/diff_drive_odometry.sv =====
// ---------------------------------------------------------------------------
// diff_drive_odometry - differential drive wheel odometry
// Encoder counts and a timestamp in, filtered speeds and pose out.
// ---------------------------------------------------------------------------
//   req_ channel carries one word: both cumulative encoder counts and a
//   millisecond timestamp. rsp_ channel returns one word per request: x, y,
//   heading, filtered wheel speeds and a rejected flag. Both use valid/stall.
//   csr_ writes set wheel scales, speed limit, filter gain and wheel base;
//   write only while idle.
//   One shared 64-bit add/shift unit under a sequencer: two 64-step
//   restoring divisions, a normalising shift search, CORDIC_STEPS
//   vectoring and rotation steps, and two multiplies done in four
//   16-bit slices. req_stall is high from acceptance until the result is
//   taken; the next word can go in the cycle after. Synchronous reset
//   clears the pose, speeds, previous sample and the registers to their
//   defaults. While rsp_stall is high the result holds and no new word is
//   taken.
// ---------------------------------------------------------------------------
`default_nettype none
module diff_drive_odometry #(
   parameter int unsigned CORDIC_STEPS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic signed [31:0]    req_left_count,
   input  wire logic signed [31:0]    req_right_count,
   input  wire logic [31:0]           req_time_ms,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [47:0]         rsp_x_pos,
   output logic signed [47:0]         rsp_y_pos,
   output logic signed [31:0]         rsp_heading,
   output logic signed [31:0]         rsp_left_speed,
   output logic signed [31:0]         rsp_right_speed,
   output logic                       rsp_rejected,
   input  wire logic                  csr_write,
   input  wire logic [ddo_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ddo_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned STEP_W = $clog2(CORDIC_STEPS + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_DIST, ST_DIV_L, ST_CHK_L, ST_DIV_R, ST_CHK_R,
      ST_FILT_L, ST_FILT_R, ST_NORM, ST_VEC, ST_HEAD, ST_ROT_INIT,
      ST_ROT, ST_MUL_X, ST_MUL_Y, ST_POS, ST_DONE
   } state_type;

   state_type state_ff;

   logic [19:0] left_scale_ff, right_scale_ff;
   logic [15:0] speed_limit_ff;
   logic [16:0] filter_gain_ff;
   logic [27:0] wheel_base_ff;

   logic [31:0] prev_left_ff, prev_right_ff, prev_time_ff;
   logic signed [31:0] filt_left_ff, filt_right_ff;
   logic signed [47:0] pos_x_ff, pos_y_ff;
   logic signed [31:0] heading_ff, prev_heading_ff;

   logic [31:0] lc_ff, rc_ff, t_ff, dt_ff;
   logic signed [63:0] dl_ff, dr_ff;
   logic signed [63:0] sl_ff, sr_ff;
   logic bad_ff;

   // shared datapath registers
   logic signed [63:0] ax_ff, ay_ff, az_ff;
   logic [63:0] rem_ff, quo_ff, num_ff;
   logic [5:0] cnt_ff;
   logic [STEP_W-1:0] step_ff;
   logic flip_ff;
   logic signed [63:0] sum_ff, mid_ff, cos_ff;

   logic signed [63:0] xs, ys;
   logic [4:0] k5;
   logic signed [63:0] atan_k;
   logic [63:0] den_w, rem_sh, lim_w;
   logic signed [63:0] dsel, fsel, diffq, prod_w;

   always_comb begin
      k5     = 5'(step_ff);
      atan_k = ddo_pkg::atan_q29(k5);
      xs     = ax_ff >>> k5;
      ys     = ay_ff >>> k5;
      den_w  = {28'd0, dt_ff, 4'd0};
      rem_sh = {rem_ff[62:0], num_ff[63]};
      lim_w  = 64'(speed_limit_ff) * 64'd40960;
      dsel   = (state_ff == ST_DIV_L || state_ff == ST_CHK_L) ? dl_ff : dr_ff;
      fsel   = (state_ff == ST_FILT_L) ? 64'(filt_left_ff) : 64'(filt_right_ff);
      diffq  = ((state_ff == ST_FILT_L) ? sl_ff : sr_ff) - fsel;
      // 16 bits of the magnitude per step
      prod_w = 64'(num_ff[15:0]) * 64'(cos_ff[30:0]);
   end

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                              input logic [5:0] bits);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (bits - 6'd1)) - 64'sd1;
      lo = -hi - 64'sd1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   logic signed [63:0] angle_ff;
   logic signed [63:0] mag_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         left_scale_ff   <= 20'd65536;
         right_scale_ff  <= 20'd65536;
         speed_limit_ff  <= 16'd1000;
         filter_gain_ff  <= 17'd32768;
         wheel_base_ff   <= 28'd13107200;
         prev_left_ff    <= '0;
         prev_right_ff   <= '0;
         prev_time_ff    <= '0;
         filt_left_ff    <= '0;
         filt_right_ff   <= '0;
         pos_x_ff        <= '0;
         pos_y_ff        <= '0;
         heading_ff      <= '0;
         prev_heading_ff <= '0;
         rsp_valid       <= 1'b0;
         req_stall       <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               ddo_pkg::REG_LEFT_MM_PER_TICK:  left_scale_ff  <= csr_data[19:0];
               ddo_pkg::REG_RIGHT_MM_PER_TICK: right_scale_ff <= csr_data[19:0];
               ddo_pkg::REG_SPEED_LIMIT:       speed_limit_ff <= csr_data[15:0];
               ddo_pkg::REG_FILTER_GAIN:       filter_gain_ff <= csr_data[16:0];
               ddo_pkg::REG_WHEEL_BASE:        wheel_base_ff  <= csr_data[27:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  lc_ff     <= req_left_count;
                  rc_ff     <= req_right_count;
                  t_ff      <= req_time_ms;
                  dt_ff     <= req_time_ms - prev_time_ff;
                  req_stall <= 1'b1;
                  bad_ff    <= 1'b0;
                  state_ff  <= ST_DIST;
               end
            end
            ST_DIST: begin
               dl_ff <= 64'(signed'(lc_ff - prev_left_ff)) *
                        64'(signed'({1'b0, left_scale_ff}));
               dr_ff <= 64'(signed'(rc_ff - prev_right_ff)) *
                        64'(signed'({1'b0, right_scale_ff}));
               if (dt_ff == 32'd0) begin
                  bad_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_DIV_L;
                  cnt_ff   <= 6'd0;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  num_ff   <= '0;
               end
            end
            ST_DIV_L, ST_DIV_R: begin
               // restoring divide, one bit per cycle over 64 bits
               if (cnt_ff == 6'd0 && num_ff == 64'd0 && quo_ff == 64'd0 &&
                   rem_ff == 64'd0) begin
                  num_ff <= mag64(dsel) * 64'd1000;
                  cnt_ff <= 6'd63;
                  quo_ff <= 64'd1;
               end else begin
                  if (rem_sh >= den_w) begin
                     rem_ff <= rem_sh - den_w;
                     quo_ff <= {quo_ff[62:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[62:0], 1'b0};
                  end
                  num_ff <= {num_ff[62:0], 1'b0};
                  cnt_ff <= cnt_ff - 6'd1;
                  if (cnt_ff == 6'd0)
                     state_ff <= (state_ff == ST_DIV_L) ? ST_CHK_L : ST_CHK_R;
               end
            end
            ST_CHK_L, ST_CHK_R: begin
               // quo carries a marker bit shifted out; clean 64-bit quotient
               if (quo_ff > lim_w || (quo_ff == lim_w && rem_ff != 64'd0))
                  bad_ff <= 1'b1;
               if (state_ff == ST_CHK_L)
                  sl_ff <= dsel[63] ? -64'(quo_ff > 64'd2147483647 ?
                           64'd2147483647 : quo_ff) :
                           64'(quo_ff > 64'd2147483647 ? 64'd2147483647 : quo_ff);
               else
                  sr_ff <= dsel[63] ? -64'(quo_ff > 64'd2147483647 ?
                           64'd2147483647 : quo_ff) :
                           64'(quo_ff > 64'd2147483647 ? 64'd2147483647 : quo_ff);
               cnt_ff <= 6'd0;
               rem_ff <= '0;
               quo_ff <= '0;
               num_ff <= '0;
               if (state_ff == ST_CHK_L)
                  state_ff <= ST_DIV_R;
               else
                  state_ff <= ST_FILT_L;
            end
            ST_FILT_L, ST_FILT_R: begin
               if (bad_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  if (state_ff == ST_FILT_L) begin
                     filt_left_ff <= 32'(sat(fsel +
                                    ((64'(signed'({1'b0, filter_gain_ff})) * diffq)
                                    >>> 16), 6'd32));
                     state_ff <= ST_FILT_R;
                  end else begin
                     filt_right_ff <= 32'(sat(fsel +
                                     ((64'(signed'({1'b0, filter_gain_ff})) * diffq)
                                     >>> 16), 6'd32));
                     ax_ff    <= 64'(wheel_base_ff);
                     ay_ff    <= dr_ff - dl_ff;
                     az_ff    <= '0;
                     state_ff <= ST_NORM;
                  end
               end
            end
            ST_NORM: begin
               if (ax_ff == 64'sd0 && ay_ff == 64'sd0) begin
                  state_ff <= ST_HEAD;
               end else if (mag64(ax_ff) < (64'd1 << 52) &&
                            mag64(ay_ff) < (64'd1 << 52)) begin
                  ax_ff <= ax_ff <<< 1;
                  ay_ff <= ay_ff <<< 1;
               end else begin
                  step_ff  <= '0;
                  state_ff <= ST_VEC;
               end
            end
            ST_VEC: begin
               if (ay_ff > 0) begin
                  ax_ff <= ax_ff + ys;
                  ay_ff <= ay_ff - xs;
                  az_ff <= az_ff + atan_k;
               end else if (ay_ff < 0) begin
                  ax_ff <= ax_ff - ys;
                  ay_ff <= ay_ff + xs;
                  az_ff <= az_ff - atan_k;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(CORDIC_STEPS - 1))
                  state_ff <= ST_HEAD;
            end
            ST_HEAD: begin
               sum_ff   <= 64'(heading_ff) + az_ff;
               mid_ff   <= (64'(prev_heading_ff) + 64'(heading_ff) + az_ff) >>> 1;
               state_ff <= ST_ROT_INIT;
            end
            ST_ROT_INIT: begin
               if (sum_ff > ddo_pkg::PI_Q29)
                  heading_ff <= 32'(sum_ff - 2 * ddo_pkg::PI_Q29);
               else if (sum_ff < -ddo_pkg::PI_Q29)
                  heading_ff <= 32'(sum_ff + 2 * ddo_pkg::PI_Q29);
               else
                  heading_ff <= 32'(sum_ff);
               ax_ff <= ddo_pkg::CORDIC_K_Q30;
               ay_ff <= '0;
               if (mid_ff > ddo_pkg::HALF_PI_Q29) begin
                  az_ff <= mid_ff - ddo_pkg::PI_Q29; flip_ff <= 1'b1;
               end else if (mid_ff < -ddo_pkg::HALF_PI_Q29) begin
                  az_ff <= mid_ff + ddo_pkg::PI_Q29; flip_ff <= 1'b1;
               end else begin
                  az_ff <= mid_ff; flip_ff <= 1'b0;
               end
               step_ff  <= '0;
               state_ff <= ST_ROT;
            end
            ST_ROT: begin
               if (az_ff >= 0) begin
                  ax_ff <= ax_ff - ys;
                  ay_ff <= ay_ff + xs;
                  az_ff <= az_ff - atan_k;
               end else begin
                  ax_ff <= ax_ff + ys;
                  ay_ff <= ay_ff - xs;
                  az_ff <= az_ff + atan_k;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= ST_MUL_X;
                  // mean travel = floor((dl+dr)/2)
                  mid_ff   <= (dl_ff + dr_ff) >>> 1;
               end
            end
            ST_MUL_X, ST_MUL_Y: begin
               // |travel| * |c| >> 30 via the high/low split, 16 bits a step
               if (cnt_ff == 6'd0) begin
                  cos_ff <= 64'(mag64((state_ff == ST_MUL_X) ?
                            (flip_ff ? -ax_ff : ax_ff) : (flip_ff ? -ay_ff : ay_ff)));
                  angle_ff <= (state_ff == ST_MUL_X) ? (flip_ff ? -ax_ff : ax_ff) :
                              (flip_ff ? -ay_ff : ay_ff);
                  num_ff    <= mag64(mid_ff) & 64'hFFFFFF;
                  mag_hi_ff <= 64'(mag64(mid_ff) >> 24);
                  quo_ff <= '0;
                  rem_ff <= '0;
                  cnt_ff <= 6'd1;
               end else if (cnt_ff <= 6'd2) begin
                  // low 24 bits in two 16/8-bit slices
                  rem_ff <= rem_ff + (64'(prod_w) << (cnt_ff == 6'd2 ? 16 : 0));
                  cnt_ff <= cnt_ff + 6'd1;
                  if (cnt_ff == 6'd2)
                     num_ff <= mag_hi_ff;
                  else
                     num_ff <= num_ff >> 16;
               end else if (cnt_ff <= 6'd4) begin
                  quo_ff <= quo_ff + (64'(prod_w) << (cnt_ff == 6'd4 ? 16 : 0));
                  num_ff <= num_ff >> 16;
                  cnt_ff <= cnt_ff + 6'd1;
               end else begin
                  sum_ff <= (((quo_ff + (rem_ff >> 24)) >> 6) == 64'd0) ? 64'sd0 :
                            (((mid_ff[63] != angle_ff[63]) && angle_ff != 0) ?
                             -64'((quo_ff + (rem_ff >> 24)) >> 6) :
                             64'((quo_ff + (rem_ff >> 24)) >> 6));
                  cnt_ff <= 6'd0;
                  state_ff <= (state_ff == ST_MUL_X) ? ST_MUL_Y : ST_POS;
                  if (state_ff == ST_MUL_X)
                     pos_x_ff <= 48'(sat(64'(pos_x_ff) +
                        ((((mid_ff[63] != angle_ff[63]) && angle_ff != 0)) ?
                         -64'((quo_ff + (rem_ff >> 24)) >> 6) :
                         64'((quo_ff + (rem_ff >> 24)) >> 6)), 6'd48));
                  else
                     pos_y_ff <= 48'(sat(64'(pos_y_ff) +
                        ((((mid_ff[63] != angle_ff[63]) && angle_ff != 0)) ?
                         -64'((quo_ff + (rem_ff >> 24)) >> 6) :
                         64'((quo_ff + (rem_ff >> 24)) >> 6)), 6'd48));
               end
            end
            ST_POS: begin
               prev_heading_ff <= heading_ff;
               prev_time_ff    <= t_ff;
               prev_left_ff    <= lc_ff;
               prev_right_ff   <= rc_ff;
               state_ff        <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid) begin
                  rsp_valid <= 1'b1;
               end else if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  req_stall <= 1'b0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_x_pos       = pos_x_ff;
   assign rsp_y_pos       = pos_y_ff;
   assign rsp_heading     = heading_ff;
   assign rsp_left_speed  = filt_left_ff;
   assign rsp_right_speed = filt_right_ff;
   assign rsp_rejected    = bad_ff;

endmodule
`default_nettype wire

// ===== design/ddo_checker.sv =====
// ---------------------------------------------------------------------------
// ddo_props - port-level checks for the odometry block
// Watches handshakes and the heading range on the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none
module ddo_props (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_heading,
   input wire logic               rsp_rejected
);

   // a held result stays valid and keeps its heading and rejected flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_heading) &&
      $stable(rsp_rejected))
      else $error("result word changed while stalled");

   // heading within plus or minus pi whenever a result is valid
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading <= 32'sd1686629713 &&
      rsp_heading >= -32'sd1686629713)
      else $error("heading out of range");

   // no new word taken while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken with result pending");

   // accepted word stalls the input next cycle
   a_accept_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accept");

endmodule

bind diff_drive_odometry ddo_props u_ddo_props (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_heading  (rsp_heading),
   .rsp_rejected (rsp_rejected)
);
`default_nettype wire
